// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion shorthands for the page allocator checker
// Clocked concurrent assertions that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising edge of clk, disabled while rst_n is low.
`define PFLA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that an implication holds on the next clock edge.
`define PFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pfla_pkg.sv -----
// ----------------------------------------------------------------------------
// pfla_pkg - shared types and codes of the page free-list allocator
// Command and status codes, controller states and the memory entry layout.
// ----------------------------------------------------------------------------
package pfla_pkg;

	localparam int ID_W     = 10;
	localparam int ID_SPACE = 1024;
	localparam int FRESH_W  = 11;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} pfla_cmd_t;

	typedef enum logic [2:0] {
		STS_OK           = 3'd0,
		STS_INVALID      = 3'd1,
		STS_BUSY         = 3'd2,
		STS_ALREADY_FREE = 3'd3,
		STS_EXHAUSTED    = 3'd4
	} pfla_status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} pfla_state_t;

	// One page entry: free mark and successor on the free list.
	typedef struct packed {
		logic              mark;
		logic [ID_W-1:0]   link;
	} pfla_entry_t;

endpackage

// ----- hw/rtl/pfla_ram.sv -----
// ----------------------------------------------------------------------------
// pfla_ram - page entry memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module pfla_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  pfla_pkg::pfla_entry_t wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output pfla_pkg::pfla_entry_t rdata
);

	pfla_pkg::pfla_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/page_free_list_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// page_free_list_allocator_unit - linked free-list page allocator
// Hands out page numbers from a free list or a bump counter and takes
// freed pages back onto the list.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the command (allocate
//   or free), s_tdata the page id and the pinned flag. Each request gives
//   exactly one result on the m_ channel: status in m_tuser, granted page in
//   m_tdata (zero for anything but a successful allocate).
//   A request first reads the page entry memory at the list head (allocate)
//   or at the page id (free); in its check cycle it then checks, writes the
//   entry back and loads the result register. The read-modify-write on that
//   memory keeps one request in flight: the next request transfers only
//   once the last is written back. m_tvalid rises when the result is registered.
//   The result register lets the next request transfer while the previous
//   result still waits; a stalled receiver holds the second request in its
//   check cycle until the result register drains.
//   Reset empties the free list and restarts the bump counter at page 1.
//   The memory needs no clearing pass: a page's entry is written when the
//   bump counter first hands it out, so marks are never read before written.
// ----------------------------------------------------------------------------
module page_free_list_allocator_unit #(
	parameter int MAX_PAGES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] page_id, [10] pinned_elsewhere, rest zero
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] granted_page, rest zero
	output logic [2:0]  m_tuser    // [2:0] status
);

	localparam int DEPTH = (MAX_PAGES < pfla_pkg::ID_SPACE) ? MAX_PAGES : pfla_pkg::ID_SPACE;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [pfla_pkg::FRESH_W-1:0] PAGE_LIMIT = pfla_pkg::FRESH_W'(DEPTH);

	// control state
	pfla_pkg::pfla_state_t              state_q, state_d;
	logic [pfla_pkg::ID_W-1:0]          list_head_q;
	logic                               list_nonempty_q;
	logic [pfla_pkg::FRESH_W-1:0]       next_fresh_q;

	// request held for the check cycle
	pfla_pkg::pfla_cmd_t                cmd_s1;
	logic [pfla_pkg::ID_W-1:0]          page_s1;
	logic                               pin_s1;

	// result register
	logic                               out_valid_q;
	pfla_pkg::pfla_status_t             out_status_q;
	logic [pfla_pkg::ID_W-1:0]          out_page_q;

	// memory port
	logic                               mem_we, mem_re;
	logic [AW-1:0]                      mem_waddr, mem_raddr;
	pfla_pkg::pfla_entry_t              mem_wdata, mem_rdata;

	logic                               in_xfer;
	logic                               commit;

	// next result and state updates
	pfla_pkg::pfla_status_t             res_status;
	logic [pfla_pkg::ID_W-1:0]          res_page;
	logic                               upd_head, upd_fresh;
	logic [pfla_pkg::ID_W-1:0]          head_d;
	logic                               nonempty_d;

	assign in_xfer = s_tvalid && s_tready;

	// Read at the list head for an allocate, at the page for a free.
	assign mem_re    = in_xfer;
	assign mem_raddr = (pfla_pkg::pfla_cmd_t'(s_tuser[0]) == pfla_pkg::CMD_FREE) ?
		s_tdata[AW-1:0] : list_head_q[AW-1:0];

	pfla_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Controller: accept in idle, check and write back in exec.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			pfla_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = pfla_pkg::S_EXEC;
				end
			end
			pfla_pkg::S_EXEC: begin
				// hold until the result register is free or draining
				if (!out_valid_q || m_tready) begin
					commit  = 1'b1;
					state_d = pfla_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pfla_pkg::S_IDLE;
			end
		endcase
	end

	// Decide the request from the entry just read.
	always_comb begin
		res_status = pfla_pkg::STS_OK;
		res_page   = '0;
		upd_head   = 1'b0;
		upd_fresh  = 1'b0;
		head_d     = list_head_q;
		nonempty_d = list_nonempty_q;
		mem_we     = 1'b0;
		mem_waddr  = page_s1[AW-1:0];
		mem_wdata  = '{mark: 1'b0, link: '0};
		if (cmd_s1 == pfla_pkg::CMD_ALLOC) begin
			if (list_nonempty_q && ({1'b0, list_head_q} < PAGE_LIMIT)) begin
				// pop: clear the mark, advance the head to the successor
				res_page   = list_head_q;
				mem_we     = commit;
				mem_waddr  = list_head_q[AW-1:0];
				mem_wdata  = '{mark: 1'b0, link: mem_rdata.link};
				upd_head   = 1'b1;
				head_d     = mem_rdata.link;
				nonempty_d = (mem_rdata.link != '0);
			end else if (next_fresh_q < PAGE_LIMIT) begin
				// bump: first write of this page's entry, mark clear
				res_page  = next_fresh_q[pfla_pkg::ID_W-1:0];
				mem_we    = commit;
				mem_waddr = next_fresh_q[AW-1:0];
				upd_fresh = 1'b1;
			end else begin
				res_status = pfla_pkg::STS_EXHAUSTED;
			end
		end else begin
			if ((page_s1 == '0) || ({1'b0, page_s1} >= next_fresh_q)) begin
				res_status = pfla_pkg::STS_INVALID;
			end else if (pin_s1) begin
				res_status = pfla_pkg::STS_BUSY;
			end else if (mem_rdata.mark) begin
				res_status = pfla_pkg::STS_ALREADY_FREE;
			end else begin
				// push: mark free, link to the old head
				mem_we     = commit;
				mem_wdata  = '{mark: 1'b1,
					link: list_nonempty_q ? list_head_q : {pfla_pkg::ID_W{1'b0}}};
				upd_head   = 1'b1;
				head_d     = page_s1;
				nonempty_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= pfla_pkg::S_IDLE;
			list_head_q     <= '0;
			list_nonempty_q <= 1'b0;
			next_fresh_q    <= pfla_pkg::FRESH_W'(1);
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit && upd_head) begin
				list_head_q     <= head_d;
				list_nonempty_q <= nonempty_d;
			end
			if (commit && upd_fresh) begin
				next_fresh_q <= next_fresh_q + pfla_pkg::FRESH_W'(1);
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload: no reset needed.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= pfla_pkg::pfla_cmd_t'(s_tuser[0]);
			page_s1 <= s_tdata[pfla_pkg::ID_W-1:0];
			pin_s1  <= s_tdata[pfla_pkg::ID_W];
		end
		if (commit) begin
			out_status_q <= res_status;
			out_page_q   <= res_page;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(16 - pfla_pkg::ID_W){1'b0}}, out_page_q};

endmodule

// ----- hw/rtl/pfla_checker.sv -----
// ----------------------------------------------------------------------------
// pfla_checker - port checks for the page allocator
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// A stalled result holds.
	`PFLA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// Only a successful allocate grants a page.
	`PFLA_ASSERT(a_grant_ok, clk, arst_n, (m_tvalid && (m_tuser != pfla_pkg::STS_OK)) |-> (m_tdata == '0), "page granted with non-ok status")

	// One request in flight: no transfer right after a transfer.
	`PFLA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "back-to-back request transfer")

	// A result appears only after a request was taken: idle and empty stays empty.
	`PFLA_ASSERT_NEXT(a_no_spurious, clk, arst_n, !m_tvalid && s_tready, !m_tvalid, "result without a request")

endmodule

bind page_free_list_allocator_unit pfla_checker u_pfla_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
